// ===== rtl/zsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsl_pkg: shared definitions of the zero-terminated sorted list engine
// Widths, operation and error codes, controller/datapath command types.
// ----------------------------------------------------------------------------
package zsl_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int VAL_W      = 32;
  localparam int OP_W       = 3;
  localparam int POS_W      = 6;
  localparam int FOUND_W    = 6;
  localparam int ERR_W      = 2;

  localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
  localparam logic [OP_W-1:0] OP_COMPACT  = 3'd3;
  localparam logic [OP_W-1:0] OP_LSEARCH  = 3'd4;
  localparam logic [OP_W-1:0] OP_BSEARCH  = 3'd5;
  localparam logic [OP_W-1:0] OP_SORT     = 3'd6;
  localparam logic [OP_W-1:0] OP_READ     = 3'd7;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_POS   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd2;
  localparam logic [ERR_W-1:0] ERR_EMPTY_SLT = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_STEP,
    CMD_STAT,
    CMD_PUT
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [CNT_W-1:0] cnt;
  } ctrl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            step_done;
  } stat_t;

endpackage

// ===== rtl/zero_terminated_sorted_list_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_terminated_sorted_list_engine_top: list engine with search and sort
// Keeps 32 signed entries, zero marking an empty slot, and runs one list
// operation per item.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries operation_i,
//    book_value_i and position_i. One item is taken at a time; in_ready_o
//    is high only while the engine waits for work.
//  - Output channel (out_valid_o / out_ready_i) carries one result per item:
//    the search hit, the read value, full/empty/sorted flags and an error.
//  - Append, insert, delete and read act in the exec step; compact and sort
//    run a step loop over the whole entry array, one shift or transposition
//    pass per step; linear search steps until the hit or the end of the
//    prefix; binary search halves the range until a hit, and on a miss one
//    more step sees the empty range.
//  - in_ready_o returns in the cycle after a result is put, so the engine
//    takes a new item only once it is through with the last one.
//  - A finished result waits in the output register; the next item is
//    taken meanwhile, and its result holds in the engine until the output
//    register is drained, so a stalled receiver stalls the input after one
//    item.
//  - Reset clears every entry to zero (empty list) and drops any result.
// ----------------------------------------------------------------------------
module zero_terminated_sorted_list_engine_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic        [zsl_pkg::OP_W-1:0]    operation_i,
  input  logic signed [zsl_pkg::VAL_W-1:0]   book_value_i,
  input  logic        [zsl_pkg::POS_W-1:0]   position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic        [zsl_pkg::FOUND_W-1:0] found_position_o,
  output logic signed [zsl_pkg::VAL_W-1:0]   read_value_o,
  output logic                               list_full_o,
  output logic                               list_empty_o,
  output logic                               list_sorted_o,
  output logic        [zsl_pkg::ERR_W-1:0]   error_code_o
);

  zsl_pkg::ctrl_t ctrl;
  zsl_pkg::stat_t stat;

  // sequencer: handshakes, state and step counter
  zsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // storage, compare/exchange network and result registers
  zsl_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .op_i     (operation_i),
    .val_i    (book_value_i),
    .pos_i    (position_i),
    .found_o  (found_position_o),
    .rd_o     (read_value_o),
    .full_o   (list_full_o),
    .empty_o  (list_empty_o),
    .sorted_o (list_sorted_o),
    .err_o    (error_code_o)
  );

endmodule

// ===== rtl/zsl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsl_ctrl: sequencer of the list engine
// Runs the handshakes and steps the datapath through each operation.
// ----------------------------------------------------------------------------
module zsl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  zsl_pkg::stat_t  stat_i,
  output zsl_pkg::ctrl_t  ctrl_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_LOOP = 3'd2;
  localparam logic [2:0] S_STAT = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [zsl_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       ovalid_q, ovalid_d;
  logic                       is_search;

  assign is_search = (stat_i.op == zsl_pkg::OP_LSEARCH) ||
                     (stat_i.op == zsl_pkg::OP_BSEARCH);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    ctrl_o.cmd = zsl_pkg::CMD_NONE;
    ctrl_o.cnt = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.cmd = zsl_pkg::CMD_LOAD;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl_o.cmd = zsl_pkg::CMD_EXEC;
        cnt_d      = '0;
        if (is_search || (stat_i.op == zsl_pkg::OP_COMPACT) ||
            (stat_i.op == zsl_pkg::OP_SORT)) begin
          state_d = S_LOOP;
        end else begin
          state_d = S_STAT;
        end
      end
      S_LOOP: begin
        ctrl_o.cmd = zsl_pkg::CMD_STEP;
        cnt_d      = cnt_q + 1'b1;
        if (is_search ? stat_i.step_done
                      : (cnt_q == zsl_pkg::CNT_W'(zsl_pkg::LIST_DEPTH - 1))) begin
          state_d = S_STAT;
        end
      end
      S_STAT: begin
        ctrl_o.cmd = zsl_pkg::CMD_STAT;
        state_d    = S_PUT;
      end
      S_PUT: begin
        // hold until the output slot is free
        if (!ovalid_q || out_ready_i) begin
          ctrl_o.cmd = zsl_pkg::CMD_PUT;
          ovalid_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ===== rtl/zsl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsl_dp: list storage and datapath
// Entry array, search bounds, status flags and the result registers.
// ----------------------------------------------------------------------------
module zsl_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  zsl_pkg::ctrl_t                     ctrl_i,
  output zsl_pkg::stat_t                     stat_o,
  input  logic        [zsl_pkg::OP_W-1:0]    op_i,
  input  logic signed [zsl_pkg::VAL_W-1:0]   val_i,
  input  logic        [zsl_pkg::POS_W-1:0]   pos_i,
  output logic        [zsl_pkg::FOUND_W-1:0] found_o,
  output logic signed [zsl_pkg::VAL_W-1:0]   rd_o,
  output logic                               full_o,
  output logic                               empty_o,
  output logic                               sorted_o,
  output logic        [zsl_pkg::ERR_W-1:0]   err_o
);

  localparam int D = zsl_pkg::LIST_DEPTH;

  logic signed [zsl_pkg::VAL_W-1:0] ent_q [D];
  logic signed [zsl_pkg::VAL_W-1:0] ent_d [D];
  logic        [zsl_pkg::OP_W-1:0]  op_q;
  logic signed [zsl_pkg::VAL_W-1:0] val_q;
  logic        [zsl_pkg::POS_W-1:0] pos_q;
  logic        [zsl_pkg::CNT_W-1:0] lo_q, lo_d, hix_q, hix_d, fnd_q, fnd_d;
  logic signed [zsl_pkg::VAL_W-1:0] rdv_q, rdv_d;
  logic        [zsl_pkg::ERR_W-1:0] err_q, err_d;
  logic        [D-2:0]              pair_q;
  logic        [D-2:0]              pair_ok;
  logic                             full_q, empty_q;

  logic        [zsl_pkg::CNT_W-1:0] n;
  logic        [D-1:0]              nz;
  logic        [zsl_pkg::CNT_W:0]   mid_w;
  logic        [zsl_pkg::CNT_W-1:0] mid;
  logic        [zsl_pkg::IDX_W-1:0] pidx, ridx;
  logic signed [zsl_pkg::VAL_W-1:0] rent;
  logic                             bad_pos, hit;

  // prefix length: index of the first empty slot
  always_comb begin
    n = zsl_pkg::CNT_W'(D);
    for (int i = D - 1; i >= 0; i--) begin
      nz[i] = (ent_q[i] != '0);
      if (!nz[i]) n = zsl_pkg::CNT_W'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < D - 1; i++) begin
      pair_ok[i] = (zsl_pkg::CNT_W'(i + 1) >= n) || (ent_q[i] <= ent_q[i + 1]);
    end
  end

  assign bad_pos = (pos_q == '0) || (int'(pos_q) > D);
  assign pidx    = zsl_pkg::IDX_W'(pos_q - 1'b1);
  assign mid_w   = ({1'b0, lo_q} + {1'b0, hix_q} - 1'b1) >> 1;
  assign mid     = mid_w[zsl_pkg::CNT_W-1:0];

  always_comb begin
    case (op_q)
      zsl_pkg::OP_LSEARCH: ridx = ctrl_i.cnt[zsl_pkg::IDX_W-1:0];
      zsl_pkg::OP_BSEARCH: ridx = mid[zsl_pkg::IDX_W-1:0];
      default:             ridx = pidx;
    endcase
  end
  assign rent = ent_q[ridx];
  assign hit  = (rent == val_q);

  always_comb begin
    stat_o.op = op_q;
    case (op_q)
      zsl_pkg::OP_LSEARCH: stat_o.step_done = (ctrl_i.cnt >= n) || hit;
      zsl_pkg::OP_BSEARCH: stat_o.step_done = (lo_q >= hix_q) || hit;
      default:             stat_o.step_done = 1'b0;
    endcase
  end

  always_comb begin
    ent_d = ent_q;
    lo_d  = lo_q;
    hix_d = hix_q;
    fnd_d = fnd_q;
    rdv_d = rdv_q;
    err_d = err_q;
    if (ctrl_i.cmd == zsl_pkg::CMD_EXEC) begin
      fnd_d = '0;
      rdv_d = '0;
      err_d = zsl_pkg::ERR_OK;
      lo_d  = '0;
      hix_d = n;
      case (op_q)
        zsl_pkg::OP_APPEND: begin
          if (n == zsl_pkg::CNT_W'(D)) err_d = zsl_pkg::ERR_FULL;
          else ent_d[n[zsl_pkg::IDX_W-1:0]] = val_q;
        end
        zsl_pkg::OP_INSERT: begin
          if (bad_pos) begin
            err_d = zsl_pkg::ERR_BAD_POS;
          end else begin
            if (nz[pidx]) begin
              for (int i = 1; i < D; i++) begin
                if (zsl_pkg::IDX_W'(i) > pidx) ent_d[i] = ent_q[i - 1];
              end
            end
            ent_d[pidx] = val_q;
          end
        end
        zsl_pkg::OP_DELETE: begin
          if (bad_pos) err_d = zsl_pkg::ERR_BAD_POS;
          else if (!nz[pidx]) err_d = zsl_pkg::ERR_EMPTY_SLT;
          else ent_d[pidx] = '0;
        end
        zsl_pkg::OP_READ: begin
          if (bad_pos) err_d = zsl_pkg::ERR_BAD_POS;
          else rdv_d = rent;
        end
        default: ;
      endcase
    end else if (ctrl_i.cmd == zsl_pkg::CMD_STEP) begin
      case (op_q)
        zsl_pkg::OP_COMPACT: begin
          // close the first gap: pull the tail up by one slot
          for (int i = 0; i < D - 1; i++) begin
            if (zsl_pkg::CNT_W'(i) >= n) ent_d[i] = ent_q[i + 1];
          end
          if (n != zsl_pkg::CNT_W'(D)) ent_d[D - 1] = '0;
        end
        zsl_pkg::OP_SORT: begin
          // one odd-even transposition pass over the used prefix
          for (int i = 0; i < D - 1; i++) begin
            if ((i % 2 == int'(ctrl_i.cnt[0])) && !pair_ok[i]) begin
              ent_d[i]     = ent_q[i + 1];
              ent_d[i + 1] = ent_q[i];
            end
          end
        end
        zsl_pkg::OP_LSEARCH: begin
          if ((ctrl_i.cnt < n) && hit) fnd_d = ctrl_i.cnt + 1'b1;
        end
        zsl_pkg::OP_BSEARCH: begin
          if (lo_q < hix_q) begin
            if (rent < val_q) lo_d = mid + 1'b1;
            else if (rent > val_q) hix_d = mid;
            else fnd_d = mid + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == zsl_pkg::CMD_LOAD) begin
      op_q  <= op_i;
      val_q <= val_i;
      pos_q <= pos_i;
    end
    lo_q  <= lo_d;
    hix_q <= hix_d;
    fnd_q <= fnd_d;
    rdv_q <= rdv_d;
    err_q <= err_d;
    if (ctrl_i.cmd == zsl_pkg::CMD_STAT) begin
      pair_q  <= pair_ok;
      full_q  <= (n == zsl_pkg::CNT_W'(D));
      empty_q <= ~|nz;
    end
    if (ctrl_i.cmd == zsl_pkg::CMD_PUT) begin
      found_o  <= zsl_pkg::FOUND_W'(fnd_q);
      rd_o     <= rdv_q;
      full_o   <= full_q;
      empty_o  <= empty_q;
      sorted_o <= &pair_q;
      err_o    <= err_q;
    end
  end

  // reset only the list contents; the rest is payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < D; i++) ent_q[i] <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule
